// File: rtl/core/nine_cell_view_change_assert.svh
`ifndef NINE_CELL_VIEW_CHANGE_ASSERT_SVH
`define NINE_CELL_VIEW_CHANGE_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define NCV_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ncv invariant violated");

// Antecedent implies consequent in the same cycle
`define NCV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ncv implication violated");

`endif

// File: rtl/core/ncv_pkg.sv
package ncv_pkg;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 16;
  localparam int GRID_W     = 11;
  localparam int CELL_W     = 10;
  localparam int ID_W       = 20;
  localparam int OP_W       = 2;
  localparam int CAT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Grid geometry
  localparam int ROW_STRIDE = 1024;
  localparam int MAX_GRID   = 1024;
  localparam int NB_COUNT   = 9;
  localparam int NB_IDX_W   = 4;
  localparam int GROUPS     = 3;
  localparam int GROUP_W    = 2;
  localparam int MASK_W     = GROUPS * NB_COUNT;
  localparam int BASE_W     = 11;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Request operations
  localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
  localparam logic [OP_W-1:0] OP_LEAVE = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;

  // Cell categories
  localparam logic [CAT_W-1:0] CAT_ENTER = 2'd0;
  localparam logic [CAT_W-1:0] CAT_LEAVE = 2'd1;
  localparam logic [CAT_W-1:0] CAT_STAY  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd3;

  // Register reset values
  localparam logic [SIZE_W-1:0] RST_CELL_WIDTH   = 16'd16;
  localparam logic [SIZE_W-1:0] RST_CELL_HEIGHT  = 16'd16;
  localparam logic [GRID_W-1:0] RST_GRID_COLUMNS = 11'd64;
  localparam logic [GRID_W-1:0] RST_GRID_ROWS    = 11'd64;

  // Neighbor order, offsets stored as offset+1 (0 is -1, 1 is 0, 2 is +1)
  localparam logic [1:0] NB_DC [NB_COUNT] = '{2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0,
                                              2'd2, 2'd2, 2'd2};
  localparam logic [1:0] NB_DR [NB_COUNT] = '{2'd1, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2,
                                              2'd0, 2'd1, 2'd2};

  typedef struct packed {
    logic [SIZE_W-1:0] cell_width;
    logic [SIZE_W-1:0] cell_height;
    logic [GRID_W-1:0] grid_columns;
    logic [GRID_W-1:0] grid_rows;
  } ncv_cfg_t;

  // One classified request: mask bit g*9+i is neighbor i of group g.
  // Group 0 is around the from cell with category first_cat, group 1 is
  // newly in view around the to cell, group 2 is still in view.
  typedef struct packed {
    logic [CAT_W-1:0]  first_cat;
    logic [BASE_W-1:0] f_col;
    logic [BASE_W-1:0] f_row;
    logic [BASE_W-1:0] t_col;
    logic [BASE_W-1:0] t_row;
    logic [MASK_W-1:0] mask;
  } ncv_entry_t;

endpackage

// File: rtl/core/ncv_if.sv
interface ncv_req_if;
  import ncv_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] from_x;
  logic [COORD_W-1:0] from_y;
  logic [COORD_W-1:0] to_x;
  logic [COORD_W-1:0] to_y;

  modport source(output valid, operation, from_x, from_y, to_x, to_y, input ready);
  modport sink(input valid, operation, from_x, from_y, to_x, to_y, output ready);
endinterface

interface ncv_cell_if;
  import ncv_pkg::*;
  logic              valid;
  logic              ready;
  logic [CAT_W-1:0]  category;
  logic [CELL_W-1:0] cell_col;
  logic [CELL_W-1:0] cell_row;
  logic [ID_W-1:0]   cell_id;
  logic              last;

  modport source(output valid, category, cell_col, cell_row, cell_id, last, input ready);
  modport sink(input valid, category, cell_col, cell_row, cell_id, last, output ready);
endinterface

// File: rtl/core/ncv_front.sv
`include "nine_cell_view_change_assert.svh"

module ncv_front (
  input  logic              clk,
  input  logic              rst,
  input  ncv_pkg::ncv_cfg_t cfg,
  ncv_req_if.sink           req,
  output logic              push_valid,
  input  logic              push_ready,
  output ncv_pkg::ncv_entry_t push_data
);
  import ncv_pkg::*;

  localparam int LANES      = 4;
  localparam int DIV_STAGES = COORD_W;
  localparam int LAST       = DIV_STAGES - 1;

  // One restoring division bit: returns {remainder, shifted dividend/quotient}
  function automatic logic [2*COORD_W-1:0] div_step(input logic [COORD_W-1:0] rem,
                                                    input logic [COORD_W-1:0] dq,
                                                    input logic [SIZE_W-1:0]  d);
    logic [COORD_W:0] trial;
    logic [COORD_W:0] diff;
    trial = {rem, dq[COORD_W-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {diff[COORD_W-1:0], dq[COORD_W-2:0], 1'b1};
    end else begin
      div_step = {trial[COORD_W-1:0], dq[COORD_W-2:0], 1'b0};
    end
  endfunction

  // Bits for offsets -1, 0, +1: cell lies inside [0, lim)
  function automatic logic [2:0] axis_ok(input logic [COORD_W-1:0] v,
                                         input logic [GRID_W-1:0]  lim);
    logic [COORD_W:0] vv;
    logic [COORD_W:0] ll;
    vv = {1'b0, v};
    ll = (COORD_W+1)'(lim);
    axis_ok[0] = (v != '0) && (vv <= ll);
    axis_ok[1] = vv < ll;
    axis_ok[2] = (vv + (COORD_W+1)'(1)) < ll;
  endfunction

  // Bits for offsets -1, 0, +1: cell a+o lies within one of b
  function automatic logic [2:0] near(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
    logic signed [COORD_W+1:0] d;
    d = $signed({2'b00, a}) - $signed({2'b00, b});
    near[0] = (d >= 0) && (d <= 2);
    near[1] = (d >= -1) && (d <= 1);
    near[2] = (d >= -2) && (d <= 0);
  endfunction

  logic                adv;
  logic [SIZE_W-1:0]   div_x;
  logic [SIZE_W-1:0]   div_y;
  logic                st_valid [DIV_STAGES];
  logic [OP_W-1:0]     st_op    [DIV_STAGES];
  logic [COORD_W-1:0]  st_rem   [DIV_STAGES][LANES];
  logic [COORD_W-1:0]  st_dq    [DIV_STAGES][LANES];
  logic [COORD_W-1:0]  src_rem  [DIV_STAGES][LANES];
  logic [COORD_W-1:0]  src_dq   [DIV_STAGES][LANES];
  logic [OP_W-1:0]     src_op   [DIV_STAGES];

  // Whole front moves together; stalls only when the output entry is stuck
  assign adv       = !push_valid || push_ready;
  assign req.ready = adv;

  // A zero cell size divides as one
  assign div_x = (cfg.cell_width == '0)  ? SIZE_W'(1) : cfg.cell_width;
  assign div_y = (cfg.cell_height == '0) ? SIZE_W'(1) : cfg.cell_height;

  // Stage inputs: lanes are from_x, to_x, from_y, to_y
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        src_op[k] = req.operation;
        for (int l = 0; l < LANES; l++) begin
          src_rem[k][l] = '0;
        end
        src_dq[k][0] = req.from_x;
        src_dq[k][1] = req.to_x;
        src_dq[k][2] = req.from_y;
        src_dq[k][3] = req.to_y;
      end else begin
        src_op[k] = st_op[k-1];
        for (int l = 0; l < LANES; l++) begin
          src_rem[k][l] = st_rem[k-1][l];
          src_dq[k][l]  = st_dq[k-1][l];
        end
      end
    end
  end

  // Divider pipeline, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_valid[k] <= 1'b0;
      end
    end else if (adv) begin
      st_valid[0] <= req.valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        st_valid[k] <= st_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_op[k] <= src_op[k];
        for (int l = 0; l < LANES; l++) begin
          {st_rem[k][l], st_dq[k][l]} <=
            div_step(src_rem[k][l], src_dq[k][l], (l < 2) ? div_x : div_y);
        end
      end
    end
  end

  // Classification of the window cells
  logic [COORD_W-1:0] fc, fr, tc, tr;
  logic [GRID_W-1:0]  lim_c, lim_r;
  logic [2:0]         fc_ok, fr_ok, tc_ok, tr_ok;
  logic [2:0]         fnear_c, fnear_r, tnear_c, tnear_r;
  logic [NB_COUNT-1:0] f_valid, t_valid, f_in_t, t_in_f;
  logic               same_cell;
  ncv_entry_t         entry_next;

  assign fc = st_dq[LAST][0];
  assign tc = st_dq[LAST][1];
  assign fr = st_dq[LAST][2];
  assign tr = st_dq[LAST][3];

  assign lim_c = (cfg.grid_columns > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : cfg.grid_columns;
  assign lim_r = (cfg.grid_rows > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : cfg.grid_rows;

  assign fc_ok   = axis_ok(fc, lim_c);
  assign fr_ok   = axis_ok(fr, lim_r);
  assign tc_ok   = axis_ok(tc, lim_c);
  assign tr_ok   = axis_ok(tr, lim_r);
  assign fnear_c = near(fc, tc);
  assign fnear_r = near(fr, tr);
  assign tnear_c = near(tc, fc);
  assign tnear_r = near(tr, fr);
  assign same_cell = (fc == tc) && (fr == tr);

  always_comb begin
    for (int i = 0; i < NB_COUNT; i++) begin
      f_valid[i] = fc_ok[NB_DC[i]] & fr_ok[NB_DR[i]];
      t_valid[i] = tc_ok[NB_DC[i]] & tr_ok[NB_DR[i]];
      f_in_t[i]  = fnear_c[NB_DC[i]] & fnear_r[NB_DR[i]];
      t_in_f[i]  = tnear_c[NB_DC[i]] & tnear_r[NB_DR[i]];
    end

    entry_next.f_col     = fc[BASE_W-1:0];
    entry_next.f_row     = fr[BASE_W-1:0];
    entry_next.t_col     = tc[BASE_W-1:0];
    entry_next.t_row     = tr[BASE_W-1:0];
    entry_next.first_cat = CAT_STAY;
    entry_next.mask      = '0;

    unique case (st_op[LAST])
      OP_ENTER: begin
        entry_next.first_cat               = CAT_ENTER;
        entry_next.mask[NB_COUNT-1:0]      = f_valid;
      end
      OP_LEAVE: begin
        entry_next.first_cat               = CAT_LEAVE;
        entry_next.mask[NB_COUNT-1:0]      = f_valid;
      end
      OP_MOVE: begin
        if (same_cell) begin
          entry_next.first_cat             = CAT_STAY;
          entry_next.mask[NB_COUNT-1:0]    = f_valid;
        end else begin
          entry_next.first_cat             = CAT_LEAVE;
          entry_next.mask[NB_COUNT-1:0]    = f_valid & ~f_in_t;
          entry_next.mask[2*NB_COUNT-1:NB_COUNT] = t_valid & ~t_in_f;
          entry_next.mask[MASK_W-1:2*NB_COUNT]   = f_valid & f_in_t;
        end
      end
      default: begin
        entry_next.mask = '0;
      end
    endcase
  end

  // Output entry; requests with no cells are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      push_valid <= 1'b0;
    end else if (adv) begin
      push_valid <= st_valid[LAST] && (entry_next.mask != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      push_data <= entry_next;
    end
  end

  `NCV_ASSERT_IMPL(a_front_nonempty, clk, rst, push_valid, push_data.mask != '0)

endmodule

// File: rtl/core/ncv_queue.sv
`include "nine_cell_view_change_assert.svh"

module ncv_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  ncv_pkg::ncv_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output ncv_pkg::ncv_entry_t pop_data
);
  import ncv_pkg::*;

  ncv_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `NCV_ASSERT_ALWAYS(a_queue_level, clk, rst, count <= QCNT_W'(QUEUE_DEPTH))

endmodule

// File: rtl/core/ncv_back.sv
`include "nine_cell_view_change_assert.svh"

module ncv_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  ncv_pkg::ncv_entry_t pop_data,
  ncv_cell_if.source          view
);
  import ncv_pkg::*;

  localparam logic [GROUP_W-1:0] GRP_FIRST = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_ENTER = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_STAY  = 2'd2;

  ncv_entry_t           work;
  logic                 work_valid;
  logic                 out_valid;
  logic [CAT_W-1:0]     out_cat;
  logic [CELL_W-1:0]    out_col;
  logic [CELL_W-1:0]    out_row;
  logic [ID_W-1:0]      out_id;
  logic                 out_last;

  logic                 adv_out;
  logic                 emit;
  logic [GROUP_W-1:0]   sel_g;
  logic [NB_IDX_W-1:0]  sel_i;
  logic [MASK_W-1:0]    pick;
  logic [MASK_W-1:0]    rest;
  logic [BASE_W-1:0]    base_c;
  logic [BASE_W-1:0]    base_r;
  logic [BASE_W-1:0]    col_sum;
  logic [BASE_W-1:0]    row_sum;
  logic [CAT_W-1:0]     cat_sel;
  logic [31:0]          id_full;

  assign adv_out   = !out_valid || view.ready;
  assign emit      = work_valid && adv_out;
  assign pop_ready = !work_valid || (adv_out && (rest == '0));

  // Lowest pending cell of the current request
  always_comb begin
    sel_g = '0;
    sel_i = '0;
    pick  = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      for (int i = NB_COUNT - 1; i >= 0; i--) begin
        if (work.mask[g*NB_COUNT + i]) begin
          sel_g                = GROUP_W'(g);
          sel_i                = NB_IDX_W'(i);
          pick                 = '0;
          pick[g*NB_COUNT + i] = 1'b1;
        end
      end
    end
  end

  assign rest = work.mask & ~pick;

  // Cell position and category
  always_comb begin
    base_c = (sel_g == GRP_ENTER) ? work.t_col : work.f_col;
    base_r = (sel_g == GRP_ENTER) ? work.t_row : work.f_row;
    col_sum = base_c + BASE_W'(NB_DC[sel_i]) - BASE_W'(1);
    row_sum = base_r + BASE_W'(NB_DR[sel_i]) - BASE_W'(1);
    unique case (sel_g)
      GRP_FIRST: cat_sel = work.first_cat;
      GRP_ENTER: cat_sel = CAT_ENTER;
      GRP_STAY:  cat_sel = CAT_STAY;
      default:   cat_sel = CAT_STAY;
    endcase
  end

  assign id_full = 32'(col_sum[CELL_W-1:0]) * 32'(ROW_STRIDE) + 32'(row_sum[CELL_W-1:0]);

  // Current request
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (pop_ready) begin
      work_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready) begin
      work <= pop_data;
    end else if (emit) begin
      work.mask <= rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (view.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cat  <= cat_sel;
      out_col  <= col_sum[CELL_W-1:0];
      out_row  <= row_sum[CELL_W-1:0];
      out_id   <= id_full[ID_W-1:0];
      out_last <= rest == '0;
    end
  end

  assign view.valid    = out_valid;
  assign view.category = out_cat;
  assign view.cell_col = out_col;
  assign view.cell_row = out_row;
  assign view.cell_id  = out_id;
  assign view.last     = out_last;

  `NCV_ASSERT_IMPL(a_back_work_nonempty, clk, rst, work_valid, work.mask != '0)
  `NCV_ASSERT_IMPL(a_back_more_pending, clk, rst, view.valid && view.ready && !view.last, work_valid)

endmodule

// File: rtl/core/nine_cell_view_change.sv
// Path: a request passes through the 16-stage divider, the classify register, the queue,
//   the sequencer and the output register before its first cell leaves the output register.
// Throughput: requests enter one per cycle until the 4-entry queue fills; the back end
//   emits one cell per cycle while the receiver is ready, and a request with n cells (1 to 18) holds it for all n.
// Reset (rst, synchronous): pipeline, queue and output are emptied; cell sizes return
//   to 16 and grid columns and rows to 64.
module nine_cell_view_change (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ncv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ncv_pkg::CFG_DATA_W-1:0]     cfg_data,
  ncv_req_if.sink                            req,
  ncv_cell_if.source                         view
);
  import ncv_pkg::*;

  ncv_cfg_t   cfg;
  logic       push_valid;
  logic       push_ready;
  ncv_entry_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  ncv_entry_t pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_width   <= RST_CELL_WIDTH;
      cfg.cell_height  <= RST_CELL_HEIGHT;
      cfg.grid_columns <= RST_GRID_COLUMNS;
      cfg.grid_rows    <= RST_GRID_ROWS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_WIDTH:   cfg.cell_width   <= cfg_data[SIZE_W-1:0];
        REG_CELL_HEIGHT:  cfg.cell_height  <= cfg_data[SIZE_W-1:0];
        REG_GRID_COLUMNS: cfg.grid_columns <= cfg_data[GRID_W-1:0];
        REG_GRID_ROWS:    cfg.grid_rows    <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  ncv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ncv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ncv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .view      (view)
  );

endmodule

// File: bench/nine_cell_view_change_tb.sv
module nine_cell_view_change_tb;
  import ncv_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 40;      // lets the output pipeline empty, with margin
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int PHASE_COUNT    = 5;
  localparam int PHASE_ITEMS    = 72;
  localparam int STEP_COUNT     = 25;
  localparam int IDLE_PCT       = 23;

  localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [CAT_W-1:0]  category;
    logic [CELL_W-1:0] cell_col;
    logic [CELL_W-1:0] cell_row;
    logic [ID_W-1:0]   cell_id;
    logic              last;
  } cell_t;

  typedef enum logic {STEP_REQUEST, STEP_WRITE} step_kind_e;

  // One directed step: a request, or a register write between requests.
  // Typed rows carry their expected cells in TYPED_CELLS.
  typedef struct packed {
    step_kind_e          kind;
    logic [OP_W-1:0]     op;
    logic [COORD_W-1:0]  fx;
    logic [COORD_W-1:0]  fy;
    logic [COORD_W-1:0]  tx;
    logic [COORD_W-1:0]  ty;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                typed;
    logic [2:0]          typed_count;
    logic [3:0]          typed_base;
  } step_t;

  localparam cell_t TYPED_CELLS [8] = '{
    // enter at the origin, default grid
    '{CAT_ENTER, 0, 0, 0, 0},
    '{CAT_ENTER, 0, 1, 1, 0},
    '{CAT_ENTER, 1, 0, 1024, 0},
    '{CAT_ENTER, 1, 1, 1025, 1},
    // leave at the far corner cell (63,63), default grid
    '{CAT_LEAVE, 63, 63, 64575, 0},
    '{CAT_LEAVE, 63, 62, 64574, 0},
    '{CAT_LEAVE, 62, 62, 63550, 0},
    '{CAT_LEAVE, 62, 63, 63551, 1}
  };

  localparam step_t STEPS [STEP_COUNT] = '{
    // default registers after reset
    '{STEP_REQUEST, OP_ENTER, 0, 0, 0, 0, REG_CELL_WIDTH, 0, 1, 4, 0},
    '{STEP_REQUEST, OP_LEAVE, 1023, 1023, 0, 0, REG_CELL_WIDTH, 0, 1, 4, 4},
    '{STEP_REQUEST, OP_UNDEFINED, 100, 100, 200, 200, REG_CELL_WIDTH, 0, 1, 0, 0},
    '{STEP_REQUEST, OP_LEAVE, 65535, 65535, 65535, 65535, REG_CELL_WIDTH, 0, 1, 0, 0},
    '{STEP_REQUEST, OP_MOVE, 0, 0, 15, 15, REG_CELL_WIDTH, 0, 0, 0, 0},
    '{STEP_REQUEST, OP_MOVE, 20, 20, 60, 40, REG_CELL_WIDTH, 0, 0, 0, 0},
    '{STEP_REQUEST, OP_MOVE, 100, 100, 116, 100, REG_CELL_WIDTH, 0, 0, 0, 0},
    '{STEP_REQUEST, OP_MOVE, 500, 500, 0, 0, REG_CELL_WIDTH, 0, 0, 0, 0},
    '{STEP_REQUEST, OP_ENTER, 520, 300, 65535, 65535, REG_CELL_WIDTH, 0, 0, 0, 0},
    // zero cell sizes and oversized grid
    '{STEP_WRITE, OP_ENTER, 0, 0, 0, 0, REG_CELL_WIDTH, 0, 0, 0, 0},
    '{STEP_WRITE, OP_ENTER, 0, 0, 0, 0, REG_CELL_HEIGHT, 0, 0, 0, 0},
    '{STEP_WRITE, OP_ENTER, 0, 0, 0, 0, REG_GRID_COLUMNS, 2047, 0, 0, 0},
    '{STEP_WRITE, OP_ENTER, 0, 0, 0, 0, REG_GRID_ROWS, 1100, 0, 0, 0},
    '{STEP_REQUEST, OP_ENTER, 1023, 1023, 0, 0, REG_CELL_WIDTH, 0, 0, 0, 0},
    '{STEP_REQUEST, OP_MOVE, 65535, 0, 1022, 1, REG_CELL_WIDTH, 0, 0, 0, 0},
    '{STEP_REQUEST, OP_MOVE, 1023, 0, 0, 1023, REG_CELL_WIDTH, 0, 0, 0, 0},
    // largest cells, then an empty grid
    '{STEP_WRITE, OP_ENTER, 0, 0, 0, 0, REG_CELL_WIDTH, 65535, 0, 0, 0},
    '{STEP_WRITE, OP_ENTER, 0, 0, 0, 0, REG_CELL_HEIGHT, 65535, 0, 0, 0},
    '{STEP_WRITE, OP_ENTER, 0, 0, 0, 0, REG_GRID_COLUMNS, 0, 0, 0, 0},
    '{STEP_REQUEST, OP_ENTER, 65535, 65535, 0, 0, REG_CELL_WIDTH, 0, 1, 0, 0},
    // single cell grid
    '{STEP_WRITE, OP_ENTER, 0, 0, 0, 0, REG_GRID_COLUMNS, 1, 0, 0, 0},
    '{STEP_WRITE, OP_ENTER, 0, 0, 0, 0, REG_GRID_ROWS, 1, 0, 0, 0},
    '{STEP_REQUEST, OP_MOVE, 0, 0, 65535, 65535, REG_CELL_WIDTH, 0, 0, 0, 0},
    '{STEP_REQUEST, OP_LEAVE, 65534, 65535, 0, 0, REG_CELL_WIDTH, 0, 0, 0, 0},
    '{STEP_REQUEST, OP_MOVE, 0, 0, 65534, 65534, REG_CELL_WIDTH, 0, 0, 0, 0}
  };

  // Register settings for the random phases
  localparam ncv_cfg_t PHASE_CFGS [PHASE_COUNT] = '{
    '{16, 16, 64, 64},
    '{1, 3, 7, 5},
    '{40000, 1000, 2, 70},
    '{64, 64, 1024, 1024},
    '{1, 1, 2047, 1024}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  quiet;

  ncv_req_if  req_ch ();
  ncv_cell_if cell_ch ();

  nine_cell_view_change dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .view      (cell_ch)
  );

  // Local copy of the registers
  logic [SIZE_W-1:0] cur_cell_width;
  logic [SIZE_W-1:0] cur_cell_height;
  logic [GRID_W-1:0] cur_grid_columns;
  logic [GRID_W-1:0] cur_grid_rows;

  cell_t pending_cells [$];
  int    error_count;
  int    requests_sent;
  int    cells_checked;
  int    reg_writes;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Append the visible window cells around (cc,cr); with filter set, keep only
  // cells whose membership in the window around (oc,orow) matches want_in.
  function automatic void push_view_window(logic [CAT_W-1:0] cat, int cc, int cr,
                                           bit filter, int oc, int orow, bit want_in);
    int    c;
    int    r;
    int    cols;
    int    rows;
    int    id;
    bit    in_other;
    cell_t item;
    cols = (cur_grid_columns > MAX_GRID) ? MAX_GRID : int'(cur_grid_columns);
    rows = (cur_grid_rows > MAX_GRID) ? MAX_GRID : int'(cur_grid_rows);
    for (int i = 0; i < NB_COUNT; i++) begin
      c = cc + int'(NB_DC[i]) - 1;
      r = cr + int'(NB_DR[i]) - 1;
      if (c < 0 || r < 0 || c >= cols || r >= rows)
        continue;
      in_other = (c - oc >= -1) && (c - oc <= 1) && (r - orow >= -1) && (r - orow <= 1);
      if (filter && in_other != want_in)
        continue;
      id = c * ROW_STRIDE + r;
      item.category = cat;
      item.cell_col = c[CELL_W-1:0];
      item.cell_row = r[CELL_W-1:0];
      item.cell_id  = id[ID_W-1:0];
      item.last     = 1'b0;
      pending_cells.push_back(item);
    end
  endfunction

  // Expected cells of one accepted request
  function automatic void predict_view_change(logic [OP_W-1:0] op,
                                              logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                                              logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
    int w;
    int h;
    int fc;
    int fr;
    int tc;
    int tr;
    int start;
    w = (cur_cell_width == 0) ? 1 : int'(cur_cell_width);
    h = (cur_cell_height == 0) ? 1 : int'(cur_cell_height);
    fc = int'(fx) / w;
    fr = int'(fy) / h;
    tc = int'(tx) / w;
    tr = int'(ty) / h;
    start = pending_cells.size();
    unique case (op)
      OP_ENTER: push_view_window(CAT_ENTER, fc, fr, 0, 0, 0, 0);
      OP_LEAVE: push_view_window(CAT_LEAVE, fc, fr, 0, 0, 0, 0);
      OP_MOVE: begin
        if (fc == tc && fr == tr) begin
          push_view_window(CAT_STAY, tc, tr, 0, 0, 0, 0);
        end else begin
          push_view_window(CAT_LEAVE, fc, fr, 1, tc, tr, 0);
          push_view_window(CAT_ENTER, tc, tr, 1, fc, fr, 0);
          push_view_window(CAT_STAY, fc, fr, 1, tc, tr, 1);
        end
      end
      default: ;
    endcase
    if (pending_cells.size() > start)
      pending_cells[pending_cells.size() - 1].last = 1'b1;
  endfunction

  // Coordinate somewhere inside cell cell_idx; off the coordinate range it is random
  function automatic logic [COORD_W-1:0] coord_in_cell(int cell_idx, int size);
    longint v;
    v = longint'(cell_idx) * size + $urandom_range(0, size - 1);
    if (v < 0 || v > 65535)
      v = $urandom_range(0, 65535);
    return v[COORD_W-1:0];
  endfunction

  // Present one request, with random idle cycles ahead of it; returns at the
  // edge where it is taken, valid still high.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic [COORD_W-1:0] fx, input logic [COORD_W-1:0] fy,
                              input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.from_x    <= fx;
    req_ch.from_y    <= fy;
    req_ch.to_x      <= tx;
    req_ch.to_y      <= ty;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    requests_sent++;
  endtask

  // Stop sending until every expected cell is out, then let the pipe settle
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (pending_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      REG_CELL_WIDTH:   cur_cell_width   = val;
      REG_CELL_HEIGHT:  cur_cell_height  = val;
      REG_GRID_COLUMNS: cur_grid_columns = val[GRID_W-1:0];
      REG_GRID_ROWS:    cur_grid_rows    = val[GRID_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Receiver stalls
  always @(posedge clk)
    cell_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);

  // Compare each delivered cell with the oldest expectation
  cell_t got_cell;
  cell_t want_cell;
  always @(posedge clk) begin
    if (!rst && cell_ch.valid && cell_ch.ready) begin
      got_cell = '{cell_ch.category, cell_ch.cell_col, cell_ch.cell_row,
                   cell_ch.cell_id, cell_ch.last};
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected cell, got cat=%0d col=%0d row=%0d id=%0d last=%0d",
                 $time, got_cell.category, got_cell.cell_col, got_cell.cell_row,
                 got_cell.cell_id, got_cell.last);
        error_count++;
      end else begin
        want_cell = pending_cells.pop_front();
        cells_checked++;
        if (got_cell.category !== want_cell.category || got_cell.cell_col !== want_cell.cell_col
            || got_cell.cell_row !== want_cell.cell_row || got_cell.cell_id !== want_cell.cell_id
            || got_cell.last !== want_cell.last) begin
          $display("%0t: cell mismatch, expected cat=%0d col=%0d row=%0d id=%0d last=%0d",
                   $time, want_cell.category, want_cell.cell_col, want_cell.cell_row,
                   want_cell.cell_id, want_cell.last);
          $display("%0t:                  got cat=%0d col=%0d row=%0d id=%0d last=%0d",
                   $time, got_cell.category, got_cell.cell_col, got_cell.cell_row,
                   got_cell.cell_id, got_cell.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    int                 made;
    int                 roll;
    int                 eff_w;
    int                 eff_h;
    int                 cols;
    int                 rows;
    int                 fc;
    int                 fr;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_CELL_WIDTH;
    cfg_data          = '0;
    quiet             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_ENTER;
    req_ch.from_x     = '0;
    req_ch.from_y     = '0;
    req_ch.to_x       = '0;
    req_ch.to_y       = '0;
    cur_cell_width    = RST_CELL_WIDTH;
    cur_cell_height   = RST_CELL_HEIGHT;
    cur_grid_columns  = RST_GRID_COLUMNS;
    cur_grid_rows     = RST_GRID_ROWS;
    error_count       = 0;
    requests_sent     = 0;
    cells_checked     = 0;
    reg_writes        = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int s = 0; s < STEP_COUNT; s++) begin
      if (STEPS[s].kind == STEP_WRITE) begin
        wait_drain();
        write_reg(STEPS[s].reg_idx, STEPS[s].reg_val);
      end else begin
        send_request(STEPS[s].op, STEPS[s].fx, STEPS[s].fy, STEPS[s].tx, STEPS[s].ty);
        if (STEPS[s].typed) begin
          for (int k = 0; k < STEPS[s].typed_count; k++)
            pending_cells.push_back(TYPED_CELLS[STEPS[s].typed_base + k]);
        end else begin
          predict_view_change(STEPS[s].op, STEPS[s].fx, STEPS[s].fy,
                              STEPS[s].tx, STEPS[s].ty);
        end
      end
    end

    // Random phases, one register setting each
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_drain();
      write_reg(REG_CELL_WIDTH, PHASE_CFGS[ph].cell_width);
      write_reg(REG_CELL_HEIGHT, PHASE_CFGS[ph].cell_height);
      write_reg(REG_GRID_COLUMNS, CFG_DATA_W'(PHASE_CFGS[ph].grid_columns));
      write_reg(REG_GRID_ROWS, CFG_DATA_W'(PHASE_CFGS[ph].grid_rows));
      eff_w = (cur_cell_width == 0) ? 1 : int'(cur_cell_width);
      eff_h = (cur_cell_height == 0) ? 1 : int'(cur_cell_height);
      cols  = (cur_grid_columns > MAX_GRID) ? MAX_GRID : int'(cur_grid_columns);
      rows  = (cur_grid_rows > MAX_GRID) ? MAX_GRID : int'(cur_grid_rows);
      made  = 0;
      while (made < PHASE_ITEMS) begin
        // no idling on either side for a stretch of the second phase
        quiet <= (ph == 1 && made >= 20 && made < 60);
        // sender holds off until the output has emptied
        if (ph == 2 && made == PHASE_ITEMS / 2)
          wait_drain();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          op = OP_W'($urandom_range(0, 3));
          fx = COORD_W'($urandom_range(0, 65535));
          fy = COORD_W'($urandom_range(0, 65535));
          tx = COORD_W'($urandom_range(0, 65535));
          ty = COORD_W'($urandom_range(0, 65535));
        end else begin
          op = (roll < 22) ? OP_ENTER : (roll < 36) ? OP_LEAVE : OP_MOVE;
          fx = coord_in_cell(int'($urandom_range(0, cols + 1)) - 1, eff_w);
          fy = coord_in_cell(int'($urandom_range(0, rows + 1)) - 1, eff_h);
          fc = int'(fx) / eff_w;
          fr = int'(fy) / eff_h;
          if ($urandom_range(0, 3) == 0) begin
            tx = coord_in_cell(fc, eff_w);
            ty = coord_in_cell(fr, eff_h);
          end else if ($urandom_range(0, 9) == 0) begin
            tx = coord_in_cell($urandom_range(0, cols - 1), eff_w);
            ty = coord_in_cell($urandom_range(0, rows - 1), eff_h);
          end else begin
            tx = coord_in_cell(fc + int'($urandom_range(0, 6)) - 3, eff_w);
            ty = coord_in_cell(fr + int'($urandom_range(0, 6)) - 3, eff_h);
          end
        end
        send_request(op, fx, fy, tx, ty);
        predict_view_change(op, fx, fy, tx, ty);
        if (op != OP_UNDEFINED)
          made++;
      end
    end

    quiet <= 1'b0;
    wait_drain();
    if (pending_cells.size() != 0) begin
      $display("%0t: %0d expected cells never arrived", $time, pending_cells.size());
      error_count += pending_cells.size();
    end

    $display("Ran %0d requests through %0d register writes and %0d random settings,",
             requests_sent, reg_writes, PHASE_COUNT);
    $display("checked %0d cells, %0d errors", cells_checked, error_count);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
